@@ hw/rtl/gh_pkg.sv @@
// Shared types, constants and the base32 character lookup for the geohash encoder.
package gh_pkg;

	// Character count field and base32 group size
	localparam int LEN_W       = 4;
	localparam int CHAR_W      = 5;
	localparam int DEFAULT_LEN = 6;

	// Base32 alphabet, first character in the top byte
	localparam logic [8*32-1:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

	// Per-item control that travels alongside the bisection data
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             inv;
	} gh_meta_t;

	// Five-bit group to ASCII character
	function automatic logic [7:0] gh_ascii(input logic [CHAR_W-1:0] code);
		return ALPHABET[(5'd31 - code) * 8 +: 8];
	endfunction

endpackage

@@ hw/rtl/geohash_encoder.sv @@
// Geohash encoder top level: input stage, bisection pipeline and character serialiser.
//
//  channel | direction | beat contents                         | handshake
//  in      | input     | latitude, longitude, length_req       | in_valid / in_stall
//  out     | output    | hash_char, last, invalid              | out_valid / out_stall
//
// A beat passes the input stage, one bisection stage per step, the serialiser item
// holder and the output register; NSTEP, the bisections per coordinate, is
// (MAX_CHARS*5+1)/2, 30 by default. An item stays in the serialiser for length
// characters, or 1 when invalid; a new item enters every cycle while there is room.
// Reset clears valid bits and serialiser control only; no clearing pass.
// Each stage holds its beat under stall; bubbles are squeezed out stage by stage.
module geohash_encoder import gh_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int MAX_CHARS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [38:0] latitude,
	input  logic signed [39:0] longitude,
	input  logic [3:0]         length_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         hash_char,
	output logic               last,
	output logic               invalid
);

	localparam int RW    = FRAC_BITS + 9;
	localparam int NSTEP = (MAX_CHARS * CHAR_W + 1) / 2;
	localparam int NB    = 2 * NSTEP;

	logic          v_p     [0:NSTEP];
	logic          stall_p [0:NSTEP];
	logic [RW-1:0] rlng_p  [0:NSTEP];
	logic [RW-1:0] rlat_p  [0:NSTEP];
	logic [NB-1:0] bits_p  [0:NSTEP];
	gh_meta_t      meta_p  [0:NSTEP];

	// Input stage
	gh_prep #(
		.FRAC_BITS(FRAC_BITS),
		.MAX_CHARS(MAX_CHARS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.latitude  (latitude),
		.longitude (longitude),
		.length_req(length_req),
		.v_s1      (v_p[0]),
		.stall_i   (stall_p[0]),
		.r_lng_s1  (rlng_p[0]),
		.r_lat_s1  (rlat_p[0]),
		.meta_s1   (meta_p[0])
	);

	assign bits_p[0] = '0;

	// Bisection pipeline, one step per stage
	for (genvar g = 1; g <= NSTEP; g++) begin : g_step
		gh_bisect #(
			.FRAC_BITS(FRAC_BITS),
			.MAX_CHARS(MAX_CHARS),
			.STEP     (g)
		) u_bisect (
			.clk     (clk),
			.arst_n  (arst_n),
			.v_i     (v_p[g-1]),
			.stall_o (stall_p[g-1]),
			.r_lng_i (rlng_p[g-1]),
			.r_lat_i (rlat_p[g-1]),
			.bits_i  (bits_p[g-1]),
			.meta_i  (meta_p[g-1]),
			.v_sk    (v_p[g]),
			.stall_i (stall_p[g]),
			.r_lng_sk(rlng_p[g]),
			.r_lat_sk(rlat_p[g]),
			.bits_sk (bits_p[g]),
			.meta_sk (meta_p[g])
		);
	end

	// Character output
	gh_serial #(
		.MAX_CHARS(MAX_CHARS)
	) u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_i      (v_p[NSTEP]),
		.stall_o  (stall_p[NSTEP]),
		.bits_i   (bits_p[NSTEP]),
		.meta_i   (meta_p[NSTEP]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hash_char(hash_char),
		.last     (last),
		.invalid  (invalid)
	);

endmodule

@@ hw/rtl/gh_prep.sv @@
// Input stage: range check, length resolution and offset of both coordinates.
module gh_prep import gh_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int MAX_CHARS = 12,
	localparam int RW = FRAC_BITS + 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [38:0]    latitude,
	input  logic signed [39:0]    longitude,
	input  logic [LEN_W-1:0]      length_req,
	output logic                  v_s1,
	input  logic                  stall_i,
	output logic [RW-1:0]         r_lng_s1,
	output logic [RW-1:0]         r_lat_s1,
	output gh_meta_t              meta_s1
);

	localparam int CW = FRAC_BITS + 10;
	localparam logic signed [CW-1:0] LNG_HALF = CW'(180) <<< FRAC_BITS;
	localparam logic signed [CW-1:0] LAT_HALF = CW'(90) <<< FRAC_BITS;
	localparam logic [LEN_W-1:0] DEF_LEN =
		LEN_W'((DEFAULT_LEN > MAX_CHARS) ? MAX_CHARS : DEFAULT_LEN);

	logic signed [CW-1:0] lng_w, lat_w, lng_off, lat_off;
	logic                 coord_ok, len_ok;
	gh_meta_t             meta_n;

	// Offset each coordinate so its interval starts at zero
	always_comb begin
		lng_w    = CW'(longitude);
		lat_w    = CW'(latitude);
		lng_off  = lng_w + LNG_HALF;
		lat_off  = lat_w + LAT_HALF;
		coord_ok = (lng_w >= -LNG_HALF) && (lng_w <= LNG_HALF) &&
		           (lat_w >= -LAT_HALF) && (lat_w <= LAT_HALF);
		len_ok   = (length_req != '0) && (length_req <= LEN_W'(MAX_CHARS));
		meta_n.len = len_ok ? length_req : DEF_LEN;
		meta_n.inv = !coord_ok;
	end

	assign in_stall = v_s1 && stall_i;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			r_lng_s1 <= lng_off[RW-1:0];
			r_lat_s1 <= lat_off[RW-1:0];
			meta_s1  <= meta_n;
		end
	end

endmodule

@@ hw/rtl/gh_bisect.sv @@
// One bisection step for longitude and latitude, registered.
module gh_bisect import gh_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int MAX_CHARS = 12,
	parameter int STEP      = 1,
	localparam int RW    = FRAC_BITS + 9,
	localparam int NSTEP = (MAX_CHARS * CHAR_W + 1) / 2,
	localparam int NB    = 2 * NSTEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_i,
	output logic          stall_o,
	input  logic [RW-1:0] r_lng_i,
	input  logic [RW-1:0] r_lat_i,
	input  logic [NB-1:0] bits_i,
	input  gh_meta_t      meta_i,
	output logic          v_sk,
	input  logic          stall_i,
	output logic [RW-1:0] r_lng_sk,
	output logic [RW-1:0] r_lat_sk,
	output logic [NB-1:0] bits_sk,
	output gh_meta_t      meta_sk
);

	// Half-width of each interval at this step; exact for the legal fraction sizes
	localparam logic [RW-1:0] LNG_SPAN = RW'(360) << FRAC_BITS;
	localparam logic [RW-1:0] LAT_SPAN = RW'(180) << FRAC_BITS;
	localparam logic [RW-1:0] LNG_H    = LNG_SPAN >> STEP;
	localparam logic [RW-1:0] LAT_H    = LAT_SPAN >> STEP;
	// Longitude bit leads, latitude follows, most significant first
	localparam int LNG_POS = NB - 1 - 2 * (STEP - 1);
	localparam int LAT_POS = LNG_POS - 1;

	logic [RW:0]   d_lng, d_lat;
	logic          b_lng, b_lat;
	logic [RW-1:0] r_lng_n, r_lat_n;
	logic [NB-1:0] bits_n;

	// Strictly above the midpoint: remainder exceeds the half-width
	always_comb begin
		d_lng   = {1'b0, r_lng_i} - {1'b0, LNG_H} - (RW+1)'(1);
		d_lat   = {1'b0, r_lat_i} - {1'b0, LAT_H} - (RW+1)'(1);
		b_lng   = !d_lng[RW];
		b_lat   = !d_lat[RW];
		r_lng_n = b_lng ? (r_lng_i - LNG_H) : r_lng_i;
		r_lat_n = b_lat ? (r_lat_i - LAT_H) : r_lat_i;
		bits_n  = bits_i;
		bits_n[LNG_POS] = b_lng;
		bits_n[LAT_POS] = b_lat;
	end

	assign stall_o = v_sk && stall_i;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk <= 1'b0;
		end else if (!stall_o) begin
			v_sk <= v_i;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (v_i && !stall_o) begin
			r_lng_sk <= r_lng_n;
			r_lat_sk <= r_lat_n;
			bits_sk  <= bits_n;
			meta_sk  <= meta_i;
		end
	end

endmodule

@@ hw/rtl/gh_serial.sv @@
// Character serialiser: one base32 character per beat from a finished bit string.
module gh_serial import gh_pkg::*; #(
	parameter int MAX_CHARS = 12,
	localparam int NSTEP = (MAX_CHARS * CHAR_W + 1) / 2,
	localparam int NB    = 2 * NSTEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_i,
	output logic          stall_o,
	input  logic [NB-1:0] bits_i,
	input  gh_meta_t      meta_i,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    hash_char,
	output logic          last,
	output logic          invalid
);

	logic             item_v_q;
	logic [NB-1:0]    item_bits_q;
	gh_meta_t         item_meta_q;
	logic [LEN_W-1:0] idx_q;

	logic             emit, final_grp, load;
	logic [7:0]       char_n;

	// Next character and hand-over
	always_comb begin
		emit      = item_v_q && (!out_valid || !out_stall);
		final_grp = item_meta_q.inv || (idx_q == item_meta_q.len - LEN_W'(1));
		char_n    = item_meta_q.inv ? 8'd0 : gh_ascii(item_bits_q[NB-1 -: CHAR_W]);
		load      = v_i && (!item_v_q || (emit && final_grp));
	end

	assign stall_o = item_v_q && !(emit && final_grp);

	// Control: item holder and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q  <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				item_v_q <= 1'b1;
				idx_q    <= '0;
			end else if (emit) begin
				if (final_grp) begin
					item_v_q <= 1'b0;
				end else begin
					idx_q <= idx_q + LEN_W'(1);
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload: bit string shifts one group per character
	always_ff @(posedge clk) begin
		if (load) begin
			item_bits_q <= bits_i;
			item_meta_q <= meta_i;
		end else if (emit) begin
			item_bits_q <= item_bits_q << CHAR_W;
		end
		if (emit) begin
			hash_char <= char_n;
			last      <= final_grp;
			invalid   <= item_meta_q.inv;
		end
	end

	// Checks
	a_inv_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> last && (hash_char == 8'd0))
		else $error("invalid beat not single and zero");
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		item_v_q |-> (item_meta_q.len != '0) && (item_meta_q.len <= LEN_W'(MAX_CHARS)))
		else $error("held length out of range");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_v_q |-> (idx_q < item_meta_q.len))
		else $error("character index past length");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		emit && final_grp && !load |=> !item_v_q)
		else $error("holder kept item after last character");

endmodule

@@ sim/geohash_checker.sv @@
// Geohash encoder checker: watches both channels, predicts characters and compares them.
module geohash_checker import gh_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int MAX_CHARS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [38:0] latitude,
	input  logic signed [39:0] longitude,
	input  logic [3:0]         length_req,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         hash_char,
	input  logic               last,
	input  logic               invalid,
	output int                 chars_pending,
	output int                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam string B32_DIGITS = "0123456789bcdefghjkmnpqrstuvwxyz";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       inv;
	} hash_char_t;

	// characters still owed by the block, oldest first
	hash_char_t chars_due[$];

	// Bisect both intervals and queue the characters one coordinate pair gives
	function automatic void encode_coord(input logic signed [38:0] lat_in,
			input logic signed [39:0] lng_in, input logic [3:0] req);
		longint     unit, lat, lng, mid;
		longint     lat_lo, lat_hi, lng_lo, lng_hi;
		int         n_chars;
		logic [4:0] grp;
		bit         on_lng;
		hash_char_t c;
		unit   = longint'(1) << FRAC_BITS;
		lat    = lat_in;
		lng    = lng_in;
		lat_lo = -90 * unit;
		lat_hi = 90 * unit;
		lng_lo = -180 * unit;
		lng_hi = 180 * unit;
		// out-of-range coordinate: single flagged beat
		if (lat < lat_lo || lat > lat_hi || lng < lng_lo || lng > lng_hi) begin
			c = '{ch: 8'h00, last: 1'b1, inv: 1'b1};
			chars_due.push_back(c);
			return;
		end
		n_chars = (req >= 1 && req <= MAX_CHARS) ? int'(req) : DEFAULT_LEN;
		if (n_chars > MAX_CHARS)
			n_chars = MAX_CHARS;
		grp    = '0;
		on_lng = 1'b1;
		for (int i = 1; i <= n_chars * 5; i++) begin
			grp = grp << 1;
			if (on_lng) begin
				mid = lng_lo + (lng_hi - lng_lo) / 2;
				if (lng > mid) begin
					lng_lo = mid;
					grp[0] = 1'b1;
				end else begin
					lng_hi = mid;
				end
			end else begin
				mid = lat_lo + (lat_hi - lat_lo) / 2;
				if (lat > mid) begin
					lat_lo = mid;
					grp[0] = 1'b1;
				end else begin
					lat_hi = mid;
				end
			end
			// five bits make one character
			if (i % 5 == 0) begin
				c = '{ch: B32_DIGITS[grp], last: (i == n_chars * 5), inv: 1'b0};
				chars_due.push_back(c);
				grp = '0;
			end
			on_lng = !on_lng;
		end
	endfunction

	initial begin
		fail_count    = 0;
		chars_pending = 0;
	end

	// Predict on each input beat, check each output beat
	always @(posedge clk) begin
		hash_char_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				encode_coord(latitude, longitude, length_req);
			if (out_valid && !out_stall) begin
				if (chars_due.size() == 0) begin
					$display("%0t: unexpected beat char %h last %b invalid %b",
						$time, hash_char, last, invalid);
					fail_count++;
				end else begin
					want = chars_due.pop_front();
					if (hash_char !== want.ch) begin
						$display("%0t: hash_char expected %h got %h", $time, want.ch, hash_char);
						fail_count++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b got %b", $time, want.last, last);
						fail_count++;
					end
					if (invalid !== want.inv) begin
						$display("%0t: invalid expected %b got %b", $time, want.inv, invalid);
						fail_count++;
					end
				end
			end
			chars_pending = chars_due.size();
		end
	end

endmodule

@@ sim/geohash_encoder_tb.sv @@
// Geohash encoder testbench top: clock, reset, stimulus, output back-pressure and verdict.
module geohash_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC_BITS   = 30;
	localparam int     MAX_CHARS   = 12;
	localparam longint ONE         = longint'(1) << FRAC_BITS;
	localparam longint LAT_LIM     = 90 * ONE;
	localparam longint LNG_LIM     = 180 * ONE;
	localparam int     N_RANDOM    = 220;
	localparam int     DRAIN_WAIT  = 64;
	localparam int     CYCLE_LIMIT = 300000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [38:0] latitude;
	logic signed [39:0] longitude;
	logic [3:0]         length_req;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         hash_char;
	logic               last;
	logic               invalid;
	int                 chars_pending;
	int                 fail_count;
	int                 cycles = 0;
	int                 in_beats = 0;
	bit                 in_calm = 1'b0;

	always #5 clk = ~clk;

	geohash_encoder #(.FRAC_BITS(FRAC_BITS), .MAX_CHARS(MAX_CHARS)) dut (
		.clk, .arst_n, .in_valid, .in_stall, .latitude, .longitude, .length_req,
		.out_valid, .out_stall, .hash_char, .last, .invalid
	);

	geohash_checker #(.FRAC_BITS(FRAC_BITS), .MAX_CHARS(MAX_CHARS)) checker_i (
		.clk, .arst_n, .in_valid, .in_stall, .latitude, .longitude, .length_req,
		.out_valid, .out_stall, .hash_char, .last, .invalid, .chars_pending, .fail_count
	);

	// Uniform 64-bit draw in [lo, hi]
	function automatic longint draw_between(input longint lo, input longint hi);
		longint unsigned r;
		r = {$urandom, $urandom};
		return lo + longint'(r % longint'(hi - lo + 1));
	endfunction

	// Point on the bisection grid at depth k, so some midpoints are hit exactly
	function automatic longint grid_point(input longint lim);
		int     k;
		longint span;
		k    = $urandom_range(1, 30);
		span = (2 * lim) >>> k;
		return -lim + span * longint'($urandom_range(0, (1 << k) - 1) + $urandom_range(0, 1));
	endfunction

	// One input beat, entered and left at a falling edge
	task automatic send_coord(input longint lat, input longint lng, input logic [3:0] req);
		int gap;
		if (in_beats % 40 == 0)
			in_calm = ($urandom_range(0, 2) == 0);
		in_beats++;
		gap = in_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		latitude   <= lat[38:0];
		longitude  <= lng[39:0];
		length_req <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver back-pressure: a fresh stall length per beat, with calm stretches
	initial begin
		int  n;
		int  k;
		bit  calm;
		k    = 0;
		calm = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (k % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			k++;
			n = calm ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int     kind;
		longint lat;
		longint lng;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		latitude   <= '0;
		longitude  <= '0;
		length_req <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: range edges, field extremes, midpoint ties, length handling
		send_coord(0, 0, 4'd5);
		send_coord(LAT_LIM, LNG_LIM, 4'd12);
		send_coord(-LAT_LIM, -LNG_LIM, 4'd12);
		send_coord(LAT_LIM, -LNG_LIM, 4'd1);
		send_coord(-LAT_LIM, LNG_LIM, 4'd13);
		send_coord(LAT_LIM + 1, 0, 4'd6);
		send_coord(-LAT_LIM - 1, 0, 4'd6);
		send_coord(0, LNG_LIM + 1, 4'd3);
		send_coord(0, -LNG_LIM - 1, 4'd3);
		send_coord(LAT_LIM + 1, LNG_LIM + 1, 4'd12);
		send_coord((longint'(1) << 38) - 1, 0, 4'd4);
		send_coord(-(longint'(1) << 38), 0, 4'd4);
		send_coord(0, (longint'(1) << 39) - 1, 4'd4);
		send_coord(0, -(longint'(1) << 39), 4'd4);
		send_coord(1, 1, 4'd12);
		send_coord(-1, -1, 4'd12);
		send_coord(45 * ONE, 90 * ONE, 4'd0);
		send_coord(-45 * ONE, -90 * ONE, 4'd15);
		send_coord(ONE, -ONE, 4'd7);
		send_coord(LAT_LIM - 1, LNG_LIM - 1, 4'd11);
		send_coord(-LAT_LIM + 1, -LNG_LIM + 1, 4'd2);

		// random: mostly legal coordinates, some on grid lines, near edges or garbage
		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					lat = longint'({$urandom, $urandom});
					lng = longint'({$urandom, $urandom});
				end
				1, 2: begin
					lat = grid_point(LAT_LIM);
					lng = grid_point(LNG_LIM);
				end
				3: begin
					lat = ($urandom_range(0, 1) ? LAT_LIM : -LAT_LIM) + $urandom_range(0, 2) - 1;
					lng = ($urandom_range(0, 1) ? LNG_LIM : -LNG_LIM) + $urandom_range(0, 2) - 1;
				end
				default: begin
					lat = draw_between(-LAT_LIM, LAT_LIM);
					lng = draw_between(-LNG_LIM, LNG_LIM);
				end
			endcase
			send_coord(lat, lng, 4'($urandom_range(0, 15)));
		end
		in_valid <= 1'b0;

		// drain, then give the pipeline time to show any stray beat
		while (chars_pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ geohash_encoder.f @@
hw/rtl/gh_pkg.sv
hw/rtl/gh_prep.sv
hw/rtl/gh_bisect.sv
hw/rtl/gh_serial.sv
hw/rtl/geohash_encoder.sv
sim/geohash_checker.sv
sim/geohash_encoder_tb.sv
